@@ sv/tlb_fifo_address_translator_macros.svh @@
// Assertion macros shared by the translator RTL.
`ifndef TLB_FIFO_ADDRESS_TRANSLATOR_MACROS_SVH
`define TLB_FIFO_ADDRESS_TRANSLATOR_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define TLBF_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define TLBF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/tlbf_pkg.sv @@
// Shared types and constants of the TLB address translator.
package tlbf_pkg;

  // Field widths
  localparam int VA_W  = 16;
  localparam int PA_W  = 16;
  localparam int CNT_W = 32;

  // Port widths: out tdata = {misses, hits, physical}, out tuser = {alloc, hit}
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 80;
  localparam int OUT_TUSER_W = 2;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SPLIT,
    ST_LOOKUP,
    ST_MAP,
    ST_FINISH
  } state_t;

endpackage

@@ sv/tlb_fifo_address_translator.sv @@
// Translator: two divider pipelines, TLB compare and a page-map memory read-modify-write.
// Takes one address at a time: in_tready is high only while idle, so a new address is
// accepted only after the previous result is loaded into the output register.
// The two constant dividers split page and offset; a miss adds a page-map step that takes
// the frame from the page-map read (the next free one if unmapped) and writes it back.
// Reset: synchronous; then a sweep clears every page-map entry, with in_tready low.
module tlb_fifo_address_translator #(
  parameter int TLB_DEPTH   = 16,
  parameter int PAGE_COUNT  = 256,
  parameter int FRAME_BYTES = 256
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // in_tdata: [15:0] virtual_address
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [tlbf_pkg::IN_TDATA_W-1:0]     in_tdata,
  // out_tdata: [15:0] physical_address, [47:16] hits_so_far, [79:48] misses_so_far
  // out_tuser: [0] tlb_hit, [1] frame_allocated
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [tlbf_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic [tlbf_pkg::OUT_TUSER_W-1:0]    out_tuser
);

`include "tlb_fifo_address_translator_macros.svh"

  localparam int PAGE_W = $clog2(PAGE_COUNT);
  localparam int OFF_W  = $clog2(FRAME_BYTES);
  localparam int SLOT_W = (TLB_DEPTH > 1) ? $clog2(TLB_DEPTH) : 1;
  localparam int FILL_W = $clog2(TLB_DEPTH + 1);
  localparam int VA_W   = tlbf_pkg::VA_W;
  localparam int PA_W   = tlbf_pkg::PA_W;
  localparam int CNT_W  = tlbf_pkg::CNT_W;

  localparam logic [PAGE_W-1:0] LAST_PAGE = PAGE_W'(PAGE_COUNT - 1);
  localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(TLB_DEPTH);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TLB_DEPTH - 1);

  tlbf_pkg::state_t state_r, state_nxt;
  logic [PAGE_W-1:0] clr_idx_r, clr_idx_nxt;

  // Split pipelines
  logic              a_valid, b_valid;
  logic [VA_W-1:0]   a_quo, a_rem, b_rem;
  logic [PAGE_W-1:0] page_r;
  logic [OFF_W-1:0]  offset_r;

  // TLB
  logic [PAGE_W-1:0]    tlb_tag_r  [TLB_DEPTH];
  logic [PA_W-1:0]      tlb_base_r [TLB_DEPTH];
  logic [FILL_W-1:0]    fill_r;
  logic [SLOT_W-1:0]    oldest_r;
  logic [TLB_DEPTH-1:0] tlb_match;
  logic                 tlb_hit;
  logic [PA_W-1:0]      tlb_hit_base;
  logic                 tlb_full;
  logic [SLOT_W-1:0]    repl_slot;
  logic                 tlb_wr;

  // Page map memory: {valid, frame number}
  logic [PAGE_W:0]   map_mem [PAGE_COUNT];
  logic [PAGE_W:0]   map_q_r;
  logic              map_we;
  logic [PAGE_W-1:0] map_waddr;
  logic [PAGE_W:0]   map_wdata;
  logic [PAGE_W-1:0] map_frame;
  logic [PA_W-1:0]   map_base;
  logic [PAGE_W-1:0] next_frame_r;

  // Result staging and totals
  logic             hit_r, alloc_r;
  logic [PA_W-1:0]  base_r;
  logic [CNT_W-1:0] hits_r, misses_r;
  logic             lookup_step, map_step;
  logic             out_load;
  logic             out_tvalid_r;
  logic [tlbf_pkg::OUT_TDATA_W-1:0] out_tdata_r;
  logic [tlbf_pkg::OUT_TUSER_W-1:0] out_tuser_r;
  logic [PA_W-1:0]  phys;

  // Split address: page = va / FRAME_BYTES, then reduce modulo PAGE_COUNT
  tlbf_cdiv #(.DIVISOR(FRAME_BYTES)) u_split_frame (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid && in_tready),
    .in_x      (in_tdata[VA_W-1:0]),
    .out_valid (a_valid),
    .out_quo   (a_quo),
    .out_rem   (a_rem)
  );

  tlbf_cdiv #(.DIVISOR(PAGE_COUNT)) u_split_page (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (a_valid),
    .in_x      (a_quo),
    .out_valid (b_valid),
    .out_quo   (),
    .out_rem   (b_rem)
  );

  // Compare the page against every filled TLB slot
  always_comb begin
    tlb_hit_base = '0;
    for (int i = 0; i < TLB_DEPTH; i++) begin
      tlb_match[i] = (FILL_W'(i) < fill_r) && (tlb_tag_r[i] == page_r);
      if (tlb_match[i]) begin
        tlb_hit_base = tlb_hit_base | tlb_base_r[i];
      end
    end
  end

  assign tlb_hit   = |tlb_match;
  assign tlb_full  = (fill_r == FULL_FILL);
  assign repl_slot = tlb_full ? oldest_r : fill_r[SLOT_W-1:0];

  // Frame for a miss: mapped frame or the next free one
  assign map_frame = map_q_r[PAGE_W] ? map_q_r[PAGE_W-1:0] : next_frame_r;
  assign map_base  = PA_W'(32'(map_frame) * 32'(FRAME_BYTES));

  // Sequencer: next state and controls
  always_comb begin
    state_nxt   = state_r;
    clr_idx_nxt = clr_idx_r;
    in_tready   = 1'b0;
    map_we      = 1'b0;
    map_waddr   = page_r;
    map_wdata   = {1'b1, next_frame_r};
    tlb_wr      = 1'b0;
    lookup_step = 1'b0;
    map_step    = 1'b0;
    out_load    = 1'b0;
    case (state_r)
      tlbf_pkg::ST_CLEAR: begin
        map_we      = 1'b1;
        map_waddr   = clr_idx_r;
        map_wdata   = '0;
        clr_idx_nxt = clr_idx_r + PAGE_W'(1);
        if (clr_idx_r == LAST_PAGE) begin
          state_nxt = tlbf_pkg::ST_IDLE;
        end
      end
      tlbf_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          state_nxt = tlbf_pkg::ST_SPLIT;
        end
      end
      tlbf_pkg::ST_SPLIT: begin
        if (b_valid) begin
          state_nxt = tlbf_pkg::ST_LOOKUP;
        end
      end
      tlbf_pkg::ST_LOOKUP: begin
        lookup_step = 1'b1;
        state_nxt   = tlb_hit ? tlbf_pkg::ST_FINISH : tlbf_pkg::ST_MAP;
      end
      tlbf_pkg::ST_MAP: begin
        map_step  = 1'b1;
        tlb_wr    = 1'b1;
        map_we    = !map_q_r[PAGE_W];
        state_nxt = tlbf_pkg::ST_FINISH;
      end
      tlbf_pkg::ST_FINISH: begin
        if (!out_tvalid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = tlbf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tlbf_pkg::ST_IDLE;
      end
    endcase
  end

  // State and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= tlbf_pkg::ST_CLEAR;
      clr_idx_r    <= '0;
      fill_r       <= '0;
      oldest_r     <= '0;
      next_frame_r <= '0;
      hits_r       <= '0;
      misses_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_idx_r <= clr_idx_nxt;
      // Count hits and misses, sticking at all ones
      if (lookup_step) begin
        if (tlb_hit && !(&hits_r)) begin
          hits_r <= hits_r + CNT_W'(1);
        end
        if (!tlb_hit && !(&misses_r)) begin
          misses_r <= misses_r + CNT_W'(1);
        end
      end
      // Fill free slots first, then advance the oldest slot
      if (tlb_wr) begin
        if (tlb_full) begin
          oldest_r <= (oldest_r == LAST_SLOT) ? '0 : (oldest_r + SLOT_W'(1));
        end else begin
          fill_r <= fill_r + FILL_W'(1);
        end
      end
      // Hand out frames in order
      if (map_step && !map_q_r[PAGE_W]) begin
        next_frame_r <= next_frame_r + PAGE_W'(1);
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (a_valid) begin
      offset_r <= a_rem[OFF_W-1:0];
    end
    if (b_valid) begin
      page_r <= b_rem[PAGE_W-1:0];
    end
    if (lookup_step) begin
      hit_r   <= tlb_hit;
      alloc_r <= 1'b0;
      base_r  <= tlb_hit_base;
    end
    if (map_step) begin
      alloc_r <= !map_q_r[PAGE_W];
      base_r  <= map_base;
    end
    if (tlb_wr) begin
      tlb_tag_r[repl_slot]  <= page_r;
      tlb_base_r[repl_slot] <= map_base;
    end
  end

  // Page map memory: one write port, registered read of the current page
  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[map_waddr] <= map_wdata;
    end
    map_q_r <= map_mem[page_r];
  end

  // Output register
  assign phys = base_r + PA_W'(offset_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tdata_r <= {misses_r, hits_r, phys};
      out_tuser_r <= {alloc_r, hit_r};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // Checks
  `TLBF_ASSERT_SAME(a_tlb_single_match, state_r == tlbf_pkg::ST_LOOKUP, $onehot0(tlb_match),
    "page matches more than one TLB slot")
  `TLBF_ASSERT_SAME(a_tlb_oldest_full, oldest_r != '0, fill_r == FULL_FILL,
    "oldest slot moved before the TLB filled")
  `TLBF_ASSERT_SAME(a_split_in_state, b_valid, state_r == tlbf_pkg::ST_SPLIT,
    "split result outside the split state")
  `TLBF_ASSERT_SAME(a_hit_no_alloc, out_tvalid_r, !(out_tuser_r[0] && out_tuser_r[1]),
    "TLB hit reported together with a new frame")
  `TLBF_ASSERT_NEXT(a_frame_advance, map_step && !map_q_r[PAGE_W],
    next_frame_r == $past(next_frame_r) + PAGE_W'(1),
    "frame counter did not advance on allocation")

endmodule

@@ sv/tlbf_cdiv.sv @@
// Three-stage pipelined divider by a constant (reciprocal multiply plus one correction).
module tlbf_cdiv #(
  parameter int DIVISOR = 256
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic [tlbf_pkg::VA_W-1:0] in_x,
  output logic                      out_valid,
  output logic [tlbf_pkg::VA_W-1:0] out_quo,
  output logic [tlbf_pkg::VA_W-1:0] out_rem
);

  localparam int W = tlbf_pkg::VA_W;
  // floor(2^(2W) / DIVISOR): the estimate is the quotient or one below it
  localparam longint unsigned RECIP_L = (64'd1 << (2 * W)) / 64'(DIVISOR);
  localparam logic [2*W-1:0] RECIP = (2 * W)'(RECIP_L);
  localparam logic [W:0]     DIV_X = (W + 1)'(DIVISOR);
  localparam logic [W-1:0]   DIV_W = W'(DIVISOR);

  logic           v1_r, v2_r, v3_r;
  logic [W-1:0]   x1_r, x2_r;
  logic [3*W-1:0] prod_r;
  logic [W-1:0]   q0;
  logic [W-1:0]   q2_r, qd_r;
  logic [W-1:0]   r0;
  logic           corr;
  logic [W-1:0]   quo_r, rem_r;

  // Valid flags of the three stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // Stage 1: multiply by the reciprocal
  always_ff @(posedge clk) begin
    x1_r   <= in_x;
    prod_r <= (3 * W)'(in_x) * (3 * W)'(RECIP);
  end

  assign q0 = prod_r[3*W-1:2*W];

  // Stage 2: multiply the estimate back by the divisor
  always_ff @(posedge clk) begin
    x2_r <= x1_r;
    q2_r <= q0;
    qd_r <= W'((2 * W)'(q0) * (2 * W)'(DIVISOR));
  end

  // Stage 3: remainder and one-step correction
  assign r0   = x2_r - qd_r;
  assign corr = ({1'b0, r0} >= DIV_X);

  always_ff @(posedge clk) begin
    quo_r <= corr ? (q2_r + W'(1)) : q2_r;
    rem_r <= corr ? (r0 - DIV_W) : r0;
  end

  assign out_valid = v3_r;
  assign out_quo   = quo_r;
  assign out_rem   = rem_r;

endmodule
